### rtl/core/command_correlation_tracker_top_defines.svh
// Assertion macros for the command correlation tracker.
`ifndef COMMAND_CORRELATION_TRACKER_TOP_DEFINES_SVH
`define COMMAND_CORRELATION_TRACKER_TOP_DEFINES_SVH

// Same-cycle implication, reset disables the check.
`define CTT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ctt assertion failed");

// Next-cycle implication, reset disables the check.
`define CTT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ctt assertion failed");

`endif

### rtl/core/ctt_pkg.sv
package ctt_pkg;

    localparam int CFG_W          = 11;
    localparam int DEPTH_DEFAULT  = 1024;
    localparam logic [CFG_W-1:0] CAP_RESET = 11'd1024;

    localparam logic [1:0] OP_BEGIN  = 2'd0;
    localparam logic [1:0] OP_END    = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [31:0] code;
        logic        done;
        logic [7:0]  pstate;
        logic [63:0] start;
        logic [31:0] cmd;
        logic [63:0] id;
    } entry_t;

    typedef struct packed {
        logic        status;
        logic [63:0] id;
        logic [31:0] cmd;
        logic [63:0] start;
        logic [7:0]  pstate;
        logic        done;
        logic [31:0] code;
    } result_t;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic scan;
        logic load_out;
    } ctrl_t;

    typedef struct packed {
        logic is_search;
        logic hit;
        logic scan_done;
    } stat_t;

endpackage

### rtl/core/ctt_ctrl.sv
module ctt_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  ctt_pkg::stat_t stat,
    output ctt_pkg::ctrl_t ctrl
);

    ctt_pkg::state_t state_reg;
    ctt_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ctt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        ctrl           = '0;
        s_tready       = 1'b0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            ctt_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    ctrl.load_in = 1'b1;
                    state_next   = ctt_pkg::ST_EXEC;
                end
            end
            ctt_pkg::ST_EXEC:
            begin
                ctrl.exec  = 1'b1;
                state_next = stat.is_search ? ctt_pkg::ST_SCAN : ctt_pkg::ST_FIN;
            end
            ctt_pkg::ST_SCAN:
            begin
                ctrl.scan = 1'b1;
                if (stat.hit || stat.scan_done)
                begin
                    state_next = ctt_pkg::ST_FIN;
                end
            end
            ctt_pkg::ST_FIN:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    ctrl.load_out  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ctt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ctt_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

endmodule

### rtl/core/ctt_datapath.sv
module ctt_datapath
#(
    parameter int TABLE_DEPTH = ctt_pkg::DEPTH_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [ctt_pkg::CFG_W-1:0] cfg_value,
    input  logic [1:0]                opcode,
    input  logic [31:0]               command_number,
    input  logic [7:0]                protocol_state,
    input  logic [63:0]               tracking_id,
    input  logic [31:0]               completion_code,
    input  logic [63:0]               now_ms,
    input  logic [63:0]               random_word,
    input  ctt_pkg::ctrl_t            ctrl,
    output ctt_pkg::stat_t            stat,
    output ctt_pkg::result_t          result
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int PTR_W  = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W  = (PTR_W > ctt_pkg::CFG_W) ? PTR_W : ctt_pkg::CFG_W;

    ctt_pkg::entry_t mem [TABLE_DEPTH];

    logic [ctt_pkg::CFG_W-1:0] cap_reg;
    logic [PTR_W-1:0]          wp_reg;
    logic [PTR_W-1:0]          wp_next;
    logic [PTR_W-1:0]          filled_reg;
    logic [PTR_W-1:0]          filled_next;
    logic [PTR_W-1:0]          scan_addr_reg;
    logic [PTR_W-1:0]          scan_addr_next;
    logic                      rd_vld_reg;
    logic                      rd_vld_next;
    logic [ADDR_W-1:0]         rd_addr_reg;
    ctt_pkg::entry_t           rdata_reg;

    logic [1:0]  op_reg;
    logic [31:0] cmd_reg;
    logic [7:0]  pstate_reg;
    logic [63:0] tid_reg;
    logic [31:0] ccode_reg;
    logic [63:0] now_reg;
    logic [63:0] rnd_reg;

    ctt_pkg::result_t res_reg;
    ctt_pkg::result_t res_next;
    ctt_pkg::result_t out_reg;

    logic [CMP_W-1:0]  cap_ext;
    logic [CMP_W-1:0]  depth_ext;
    logic [PTR_W-1:0]  cap_eff;
    logic [PTR_W-1:0]  begin_idx;
    logic              scan_more;
    logic              issue;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    ctt_pkg::entry_t   wdata;
    ctt_pkg::entry_t   new_entry;
    ctt_pkg::entry_t   upd_entry;

    assign cap_ext   = CMP_W'(cap_reg);
    assign depth_ext = CMP_W'(TABLE_DEPTH);
    assign cap_eff   = (cap_reg == '0 || cap_ext > depth_ext) ? PTR_W'(depth_ext)
                                                             : PTR_W'(cap_ext);
    assign begin_idx = (wp_reg >= cap_eff) ? '0 : wp_reg;

    assign scan_more      = scan_addr_reg < filled_reg;
    assign stat.hit       = rd_vld_reg && (rdata_reg.id == tid_reg);
    assign stat.scan_done = !rd_vld_reg && !scan_more;
    assign stat.is_search = ((op_reg == ctt_pkg::OP_END) || (op_reg == ctt_pkg::OP_LOOKUP))
                            && (tid_reg != '0);
    assign issue          = ctrl.scan && !stat.hit && scan_more;

    always_comb
    begin
        new_entry.id     = now_reg ^ rnd_reg;
        new_entry.cmd    = cmd_reg;
        new_entry.start  = now_reg;
        new_entry.pstate = pstate_reg;
        new_entry.done   = 1'b0;
        new_entry.code   = '0;

        upd_entry = rdata_reg;
        if (op_reg == ctt_pkg::OP_END)
        begin
            upd_entry.done = 1'b1;
            upd_entry.code = ccode_reg;
        end

        we             = 1'b0;
        waddr          = begin_idx[ADDR_W-1:0];
        wdata          = new_entry;
        wp_next        = wp_reg;
        filled_next    = filled_reg;
        scan_addr_next = scan_addr_reg;
        rd_vld_next    = 1'b0;
        res_next       = res_reg;

        if (ctrl.exec)
        begin
            scan_addr_next = '0;
            if (op_reg == ctt_pkg::OP_BEGIN)
            begin
                we          = 1'b1;
                wp_next     = begin_idx + PTR_W'(1);
                filled_next = (wp_next > filled_reg) ? wp_next : filled_reg;
                res_next    = '{status: 1'b0, id: new_entry.id, cmd: new_entry.cmd,
                                start: new_entry.start, pstate: new_entry.pstate,
                                done: 1'b0, code: '0};
            end
            else if (!stat.is_search)
            begin
                res_next        = '0;
                res_next.status = 1'b1;
            end
        end

        if (ctrl.scan)
        begin
            if (issue)
            begin
                rd_vld_next    = 1'b1;
                scan_addr_next = scan_addr_reg + PTR_W'(1);
            end
            if (stat.hit)
            begin
                we       = 1'b1;
                waddr    = rd_addr_reg;
                wdata    = upd_entry;
                res_next = '{status: 1'b0, id: upd_entry.id, cmd: upd_entry.cmd,
                             start: upd_entry.start, pstate: upd_entry.pstate,
                             done: upd_entry.done, code: upd_entry.code};
            end
            else if (stat.scan_done)
            begin
                res_next        = '0;
                res_next.status = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= ctt_pkg::CAP_RESET;
            wp_reg        <= '0;
            filled_reg    <= '0;
            scan_addr_reg <= '0;
            rd_vld_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_value;
            end
            wp_reg        <= wp_next;
            filled_reg    <= filled_next;
            scan_addr_reg <= scan_addr_next;
            rd_vld_reg    <= rd_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_in)
        begin
            op_reg     <= opcode;
            cmd_reg    <= command_number;
            pstate_reg <= protocol_state;
            tid_reg    <= tracking_id;
            ccode_reg  <= completion_code;
            now_reg    <= now_ms;
            rnd_reg    <= random_word;
        end
        if (issue)
        begin
            rd_addr_reg <= scan_addr_reg[ADDR_W-1:0];
        end
        res_reg <= res_next;
        if (ctrl.load_out)
        begin
            out_reg <= res_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[scan_addr_reg[ADDR_W-1:0]];
    end

    assign result = out_reg;

endmodule

### rtl/core/command_correlation_tracker_top.sv
// Command correlation tracker: a table of outstanding commands.
// Input words arrive on s_tvalid/s_tready; s_tuser carries the opcode
// (begin, end, lookup) and s_tdata the command fields. One result word
// leaves on m_tvalid/m_tready for every input word; m_tuser is the status.
// The capacity register is written over cfg_valid/cfg_ready/cfg_data.
// Begin, a zero id and an unused opcode pass from accept through the EXEC
// and FIN states to the result in the output register. End and lookup scan
// the filled entries through the single table read port, one entry per
// cycle, lowest first, until the first hit or the last filled entry, at
// most TABLE_DEPTH entries. One word is worked on at a time; the next word
// is accepted in the cycle after its result is loaded.
// The output register holds a finished result while the next word is
// accepted and processed; a stalled receiver holds the result in place
// and the block waits for it only when the next result is ready.
// Reset clears the write pointer and the filled count and sets capacity to
// 1024; table contents are not cleared, and the scan only reads entries
// written since reset, so no clearing pass is run.
`include "command_correlation_tracker_top_defines.svh"

module command_correlation_tracker_top
#(
    parameter int TABLE_DEPTH = ctt_pkg::DEPTH_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [ctt_pkg::CFG_W-1:0] cfg_data,     // capacity_in_use
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // command_number, protocol_state, tracking_id, completion_code, now_ms, random_word
    input  logic [263:0]              s_tdata,
    input  logic [1:0]                s_tuser,      // opcode
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // id_out, command_out, started_ms, state_out, done_flag, code_out, zero pad
    output logic [207:0]              m_tdata,
    output logic [0:0]                m_tuser       // status
);

    ctt_pkg::ctrl_t   ctrl;
    ctt_pkg::stat_t   stat;
    ctt_pkg::result_t result;

    assign cfg_ready = 1'b1;

    ctt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    ctt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_value       (cfg_data),
        .opcode          (s_tuser),
        .command_number  (s_tdata[31:0]),
        .protocol_state  (s_tdata[39:32]),
        .tracking_id     (s_tdata[103:40]),
        .completion_code (s_tdata[135:104]),
        .now_ms          (s_tdata[199:136]),
        .random_word     (s_tdata[263:200]),
        .ctrl            (ctrl),
        .stat            (stat),
        .result          (result)
    );

    assign m_tuser = result.status;
    assign m_tdata = {7'd0, result.code, result.done, result.pstate,
                      result.start, result.cmd, result.id};

    `CTT_ASSERT_NEXT(a_one_word_at_a_time, s_tvalid && s_tready, !s_tready)
    `CTT_ASSERT_NOW(a_no_result_overwrite, ctrl.load_out, !m_tvalid || m_tready)
    `CTT_ASSERT_NEXT(a_load_shows_result, ctrl.load_out, m_tvalid)
    `CTT_ASSERT_NOW(a_failed_result_zero, m_tvalid && m_tuser[0], m_tdata == '0)

endmodule

### tb/tb_command_correlation_tracker_top.sv
module tb_command_correlation_tracker_top;

    localparam int TABLE_DEPTH      = ctt_pkg::DEPTH_DEFAULT;
    localparam int PHASES           = 8;
    localparam int ITEMS_PER_PHASE  = 70;
    localparam int ID_POOL_MAX      = 64;
    localparam int LONG_HOLD_AT     = 125;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT      = 2000000;

    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam logic        STATUS_OK   = 1'b0;
    localparam logic        STATUS_MISS = 1'b1;
    localparam logic [63:0] ONES64      = {64{1'b1}};
    localparam logic [31:0] ONES32      = {32{1'b1}};
    localparam logic [63:0] TOP_BIT_ID  = 64'h8000_0000_0000_0001;

    localparam ctt_pkg::result_t MISS_RESULT = '{status: STATUS_MISS, default: '0};

    typedef struct {
        logic [1:0]       op;
        logic [31:0]      cmd;
        logic [7:0]       pst;
        logic [63:0]      tid;
        logic [31:0]      code;
        logic [63:0]      now_ms;
        logic [63:0]      rnd;
        bit               typed;
        ctt_pkg::result_t res;
    } stim_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [ctt_pkg::CFG_W-1:0] cfg_data;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [263:0]              s_tdata;
    logic [1:0]                s_tuser;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [207:0]              m_tdata;
    logic [0:0]                m_tuser;

    logic [63:0]               tbl_id    [TABLE_DEPTH];
    logic [31:0]               tbl_cmd   [TABLE_DEPTH];
    logic [63:0]               tbl_start [TABLE_DEPTH];
    logic [7:0]                tbl_pst   [TABLE_DEPTH];
    logic                      tbl_done  [TABLE_DEPTH];
    logic [31:0]               tbl_code  [TABLE_DEPTH];
    int                        wr_ptr;
    int                        filled;
    logic [ctt_pkg::CFG_W-1:0] cap_reg;

    ctt_pkg::result_t          awaited_replies [$];
    logic [63:0]               issued_ids [$];
    stim_row_t                 dir_rows [$];

    int                        err_cnt        = 0;
    int                        cycle_cnt      = 0;
    int                        words_out      = 0;
    int                        stall_left     = 0;
    int                        burst_left     = 0;
    int                        rx_roll;
    bit                        long_hold_done = 1'b0;

    command_correlation_tracker_top u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic ctt_pkg::result_t entry_result(int slot);
        ctt_pkg::result_t res;
        res.status = STATUS_OK;
        res.id     = tbl_id[slot];
        res.cmd    = tbl_cmd[slot];
        res.start  = tbl_start[slot];
        res.pstate = tbl_pst[slot];
        res.done   = tbl_done[slot];
        res.code   = tbl_code[slot];
        return res;
    endfunction

    function automatic ctt_pkg::result_t track_command(logic [1:0] op, logic [31:0] cmd,
                                                       logic [7:0] pst, logic [63:0] tid,
                                                       logic [31:0] code, logic [63:0] now_ms,
                                                       logic [63:0] rnd);
        int slot;
        int lim;
        lim = (cap_reg == 0 || cap_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(cap_reg);
        if (op == ctt_pkg::OP_BEGIN)
        begin
            if (wr_ptr >= lim)
                wr_ptr = 0;
            slot = wr_ptr;
            tbl_id[slot]    = now_ms ^ rnd;
            tbl_cmd[slot]   = cmd;
            tbl_start[slot] = now_ms;
            tbl_pst[slot]   = pst;
            tbl_done[slot]  = 1'b0;
            tbl_code[slot]  = '0;
            wr_ptr = slot + 1;
            if (wr_ptr > filled)
                filled = wr_ptr;
            return entry_result(slot);
        end
        if ((op != ctt_pkg::OP_END && op != ctt_pkg::OP_LOOKUP) || tid == '0)
            return MISS_RESULT;
        slot = -1;
        for (int i = 0; i < filled; i++)
        begin
            if (slot < 0 && tbl_id[i] == tid)
                slot = i;
        end
        if (slot < 0)
            return MISS_RESULT;
        if (op == ctt_pkg::OP_END)
        begin
            tbl_done[slot] = 1'b1;
            tbl_code[slot] = code;
        end
        return entry_result(slot);
    endfunction

    function automatic int pick_gap(bit fast);
        int r;
        r = $urandom_range(0, 99);
        if (fast || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            err_cnt++;
            if (err_cnt < 100)
                $display("%0t: %s mismatch: expected %h actual %h", $time, name, want, got);
        end
    endtask

    task automatic check_reply();
        ctt_pkg::result_t want;
        if (awaited_replies.size() == 0)
        begin
            err_cnt++;
            $display("%0t: unexpected result word: expected none actual status %h id %h",
                     $time, m_tuser, m_tdata[63:0]);
        end
        else
        begin
            want = awaited_replies.pop_front();
            compare_field("status", want.status, m_tuser[0]);
            compare_field("id_out", want.id, m_tdata[63:0]);
            compare_field("command_out", want.cmd, m_tdata[95:64]);
            compare_field("started_ms", want.start, m_tdata[159:96]);
            compare_field("state_out", want.pstate, m_tdata[167:160]);
            compare_field("done_flag", want.done, m_tdata[168]);
            compare_field("code_out", want.code, m_tdata[200:169]);
        end
    endtask

    // hold the word until accepted; valid stays high for the caller to lower
    task automatic offer_word(logic [1:0] op, logic [31:0] cmd, logic [7:0] pst,
                              logic [63:0] tid, logic [31:0] code, logic [63:0] now_ms,
                              logic [63:0] rnd, bit typed, ctt_pkg::result_t typed_res);
        ctt_pkg::result_t model_res;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {rnd, now_ms, code, tid, pst, cmd};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        model_res = track_command(op, cmd, pst, tid, code, now_ms, rnd);
        awaited_replies.push_back(typed ? typed_res : model_res);
        if (op == ctt_pkg::OP_BEGIN && model_res.id != '0)
        begin
            issued_ids.push_back(model_res.id);
            if (issued_ids.size() > ID_POOL_MAX)
                void'(issued_ids.pop_front());
        end
    endtask

    task automatic idle_after(bit fast);
        int gap;
        gap = pick_gap(fast);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_replies();
        s_tvalid <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_capacity(logic [ctt_pkg::CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cap_reg = value;
    endtask

    task automatic add_row(logic [1:0] op, logic [31:0] cmd, logic [7:0] pst, logic [63:0] tid,
                           logic [31:0] code, logic [63:0] now_ms, logic [63:0] rnd,
                           bit typed, ctt_pkg::result_t res);
        stim_row_t row;
        row.op     = op;
        row.cmd    = cmd;
        row.pst    = pst;
        row.tid    = tid;
        row.code   = code;
        row.now_ms = now_ms;
        row.rnd    = rnd;
        row.typed  = typed;
        row.res    = res;
        dir_rows.push_back(row);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                check_reply();
                words_out++;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!long_hold_done && words_out >= LONG_HOLD_AT)
            begin
                long_hold_done = 1'b1;
                stall_left = LONG_HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end
            else if (burst_left > 0)
            begin
                burst_left--;
                m_tready <= 1'b1;
            end
            else
            begin
                rx_roll = $urandom_range(0, 99);
                if (rx_roll < 55)
                    m_tready <= 1'b1;
                else if (rx_roll < 62)
                begin
                    burst_left = $urandom_range(20, 120);
                    m_tready <= 1'b1;
                end
                else if (rx_roll < 96)
                begin
                    stall_left = $urandom_range(0, 2);
                    m_tready <= 1'b0;
                end
                else
                begin
                    stall_left = $urandom_range(10, 50);
                    m_tready <= 1'b0;
                end
            end
        end
        else
        begin
            m_tready <= 1'b0;
        end
    end

    initial
    begin
        logic [ctt_pkg::CFG_W-1:0] phase_caps [PHASES];
        logic [1:0]  op;
        logic [31:0] cmd;
        logic [7:0]  pst;
        logic [63:0] tid;
        logic [31:0] code;
        logic [63:0] now_ms;
        logic [63:0] rnd;
        logic [63:0] known;
        int          r;
        bit          fast;

        wr_ptr         = 0;
        filled         = 0;
        cap_reg        = ctt_pkg::CAP_RESET;

        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(ctt_pkg::OP_LOOKUP, '0, '0, ONES64, '0, '0, '0, 1'b1, MISS_RESULT);
        add_row(ctt_pkg::OP_END, ONES32, 8'hFF, '0, ONES32, ONES64, ONES64, 1'b1, MISS_RESULT);
        add_row(OP_UNUSED, ONES32, 8'hFF, ONES64, ONES32, ONES64, ONES64, 1'b1, MISS_RESULT);
        add_row(ctt_pkg::OP_BEGIN, ONES32, 8'hFF, '0, ONES32, ONES64, '0, 1'b1,
                '{status: STATUS_OK, id: ONES64, cmd: ONES32, start: ONES64, pstate: 8'hFF,
                  done: 1'b0, code: 32'd0});
        add_row(ctt_pkg::OP_BEGIN, '0, '0, ONES64, '0, '0, '0, 1'b1,
                '{status: STATUS_OK, default: '0});
        add_row(ctt_pkg::OP_LOOKUP, '0, '0, '0, '0, '0, '0, 1'b1, MISS_RESULT);
        add_row(ctt_pkg::OP_BEGIN, 32'd1, 8'h80, '0, '0, 64'd1, 64'h8000_0000_0000_0000, 1'b1,
                '{status: STATUS_OK, id: TOP_BIT_ID, cmd: 32'd1, start: 64'd1, pstate: 8'h80,
                  done: 1'b0, code: 32'd0});
        add_row(ctt_pkg::OP_LOOKUP, '0, '0, ONES64, '0, '0, '0, 1'b0, '0);
        add_row(ctt_pkg::OP_END, '0, '0, ONES64, ONES32, '0, '0, 1'b0, '0);
        add_row(ctt_pkg::OP_LOOKUP, '0, '0, ONES64, '0, '0, '0, 1'b0, '0);
        add_row(ctt_pkg::OP_END, '0, '0, TOP_BIT_ID, '0, '0, '0, 1'b0, '0);
        add_row(ctt_pkg::OP_END, '0, '0, 64'h1234, 32'h1234, '0, '0, 1'b1, MISS_RESULT);
        add_row(ctt_pkg::OP_BEGIN, 32'h8000_0000, 8'h7F, '0, '0, 64'h0F0F_0F0F_0F0F_0F0F,
                64'hF0F0_F0F0_F0F0_F0F0, 1'b0, '0);
        add_row(ctt_pkg::OP_LOOKUP, '0, '0, ONES64, '0, '0, '0, 1'b0, '0);
        add_row(ctt_pkg::OP_END, '0, '0, ONES64, 32'h5A5A_5A5A, '0, '0, 1'b0, '0);
        add_row(OP_UNUSED, '0, '0, ONES64, 32'h1, '0, '0, 1'b1, MISS_RESULT);
        add_row(ctt_pkg::OP_LOOKUP, '0, '0, TOP_BIT_ID, '0, '0, '0, 1'b0, '0);
        add_row(ctt_pkg::OP_LOOKUP, '0, '0, 64'd1, '0, '0, '0, 1'b1, MISS_RESULT);

        foreach (dir_rows[i])
        begin
            offer_word(dir_rows[i].op, dir_rows[i].cmd, dir_rows[i].pst, dir_rows[i].tid,
                       dir_rows[i].code, dir_rows[i].now_ms, dir_rows[i].rnd,
                       dir_rows[i].typed, dir_rows[i].res);
            idle_after(1'b0);
        end

        // lowered capacities wrap the pointer; zero and oversize act as full depth
        phase_caps[0] = 11'd1;
        phase_caps[1] = 11'd2047;
        phase_caps[2] = 11'd2;
        phase_caps[3] = 11'd0;
        phase_caps[4] = 11'($urandom_range(4, 64));
        phase_caps[5] = 11'd1024;
        phase_caps[6] = 11'd5;
        phase_caps[7] = 11'($urandom_range(1, 1024));

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_replies();
            set_capacity(phase_caps[ph]);
            fast = (ph % 2) == 1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                r      = $urandom_range(0, 99);
                known  = (issued_ids.size() != 0) ?
                         issued_ids[$urandom_range(0, issued_ids.size() - 1)] :
                         {$urandom, $urandom};
                cmd    = $urandom;
                pst    = 8'($urandom);
                tid    = {$urandom, $urandom};
                code   = $urandom;
                now_ms = {$urandom, $urandom};
                rnd    = {$urandom, $urandom};
                if (r < 40)
                begin
                    op = ctt_pkg::OP_BEGIN;
                    if (r < 4)
                        rnd = now_ms ^ known;
                    else if (r < 6)
                        rnd = now_ms;
                end
                else if (r < 65)
                begin
                    op  = ctt_pkg::OP_END;
                    tid = known;
                end
                else if (r < 88)
                begin
                    op  = ctt_pkg::OP_LOOKUP;
                    tid = known;
                end
                else if (r < 94)
                    op = r[0] ? ctt_pkg::OP_END : ctt_pkg::OP_LOOKUP;
                else if (r < 97)
                begin
                    op  = r[0] ? ctt_pkg::OP_END : ctt_pkg::OP_LOOKUP;
                    tid = '0;
                end
                else
                    op = OP_UNUSED;
                offer_word(op, cmd, pst, tid, code, now_ms, rnd, 1'b0, '0);
                idle_after(fast);
            end
        end

        drain_replies();
        repeat (TABLE_DEPTH + 16) @(posedge clk);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
